// ===== design/first_match_substring_search_macros.svh =====
// Assertion macros shared by the search block.
`ifndef FIRST_MATCH_SUBSTRING_SEARCH_MACROS_SVH
`define FIRST_MATCH_SUBSTRING_SEARCH_MACROS_SVH

// clocked check, off while reset is held
`define FMSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked check of an implication, off while reset is held
`define FMSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/fmss_pkg.sv =====
// Types, codes and byte helpers for the substring search block.
package fmss_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int LENGTH_WIDTH = 5;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_IGNORE_CASE    = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MATCH_MODE     = 3'd4;

    localparam logic [1:0] MODE_ANY   = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [LENGTH_WIDTH-1:0]       length;
        logic                          ignore_case;
        logic [1:0]                    mode;
    } cfg_t;

    typedef struct packed {
        logic eq;
        logic left_name;
    } match_t;

    function automatic logic is_name(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

// ===== design/first_match_substring_search.sv =====
// Top level of the first-match substring search block.
//
// Text bytes enter on the s_ channel, one byte per beat; s_tlast marks the
// final byte of a text. Each text gives exactly one result beat on the m_
// channel: m_tuser is 1 with the start offset of the leftmost qualifying
// match in m_tdata, or 0 with the text length. After a match the rest of the
// text is consumed without results. Whole-word matches wait one byte to see
// the byte after the match (or the text end).
// A beat accepted into the input register is compared there, and its result
// is loaded into the output register. Throughput is one byte per cycle while
// results are taken; all pattern bytes are compared in parallel against the
// window that ends with the byte in the input register.
// When m_tready is low with a result waiting, the pipeline holds and s_tready
// drops once the input register is full.
// Reset (aresetn low, synchronous) clears the text state, the pipeline and
// the registers to pattern length 1, case-sensitive, any-occurrence mode.
// Configuration is written on cfg_wen/cfg_addr/cfg_wdata between texts.
module first_match_substring_search #(
    parameter int MAX_PATTERN = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [fmss_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [fmss_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // text_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // match_position
    output logic                                m_tuser   // found
);

`include "first_match_substring_search_macros.svh"

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = POSITION_WIDTH;

    fmss_pkg::cfg_t cfg_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [7:0]    win_reg [MAX_PATTERN];
    logic [PW-1:0] bytes_seen_reg;
    logic          pending_reg;
    logic [PW-1:0] pending_start_reg;
    logic          done_reg;

    logic        out_valid_reg;
    logic        out_found_reg;
    logic [31:0] out_pos_reg;

    logic advance;
    logic proc;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern     <= '0;
            cfg_reg.length      <= fmss_pkg::LENGTH_WIDTH'(1);
            cfg_reg.ignore_case <= 1'b0;
            cfg_reg.mode        <= fmss_pkg::MODE_ANY;
        end else if (cfg_wen) begin
            case (cfg_addr)
                fmss_pkg::REG_PATTERN_LOW: begin
                    cfg_reg.pattern[7:0] <= cfg_wdata;
                end
                fmss_pkg::REG_PATTERN_HIGH: begin
                    cfg_reg.pattern[15:8] <= cfg_wdata;
                end
                fmss_pkg::REG_PATTERN_LENGTH: begin
                    cfg_reg.length <= cfg_wdata[fmss_pkg::LENGTH_WIDTH-1:0];
                end
                fmss_pkg::REG_IGNORE_CASE: begin
                    cfg_reg.ignore_case <= cfg_wdata[0];
                end
                fmss_pkg::REG_MATCH_MODE: begin
                    cfg_reg.mode <= cfg_wdata[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // window after shifting in the current byte
    logic [7:0] win_new [MAX_PATTERN+1];
    always_comb begin
        win_new[0] = in_byte_reg;
        for (int k = 1; k <= MAX_PATTERN; k++) begin
            win_new[k] = win_reg[k-1];
        end
    end

    logic [LW-1:0] m_len;
    always_comb begin
        if (cfg_reg.length == '0) begin
            m_len = LW'(1);
        end else if (cfg_reg.length > fmss_pkg::LENGTH_WIDTH'(MAX_PATTERN)) begin
            m_len = LW'(MAX_PATTERN);
        end else begin
            m_len = cfg_reg.length[LW-1:0];
        end
    end

    fmss_pkg::match_t mres;

    fmss_match #(
        .MAX_PATTERN(MAX_PATTERN),
        .LW(LW)
    ) u_match (
        .cfg  (cfg_reg),
        .m_len(m_len),
        .win  (win_new),
        .res  (mres)
    );

    // search decision
    logic [PW-1:0] p;
    logic [PW-1:0] len_m1;
    logic [PW-1:0] j;
    logic [PW-1:0] seen_inc;
    logic          left_ok;
    logic          hit;
    logic [PW-1:0] hit_pos;
    logic          pend_next;
    logic [PW-1:0] pend_start_next;
    logic          res_valid;
    logic          res_found;
    logic [PW-1:0] res_pos;
    logic [63:0]   res_pos64;

    always_comb begin
        p        = bytes_seen_reg;
        len_m1   = PW'(m_len - LW'(1));
        j        = p - len_m1;
        seen_inc = (p != '1) ? p + PW'(1) : p;
        left_ok  = (p == len_m1) || !mres.left_name;

        hit             = 1'b0;
        hit_pos         = '0;
        pend_next       = 1'b0;
        pend_start_next = pending_start_reg;

        if (pending_reg && !fmss_pkg::is_name(in_byte_reg)) begin
            hit     = 1'b1;
            hit_pos = pending_start_reg;
        end

        if (!hit && p >= len_m1 && mres.eq) begin
            if (cfg_reg.mode[0]) begin
                if (left_ok) begin
                    if (in_last_reg) begin
                        hit     = 1'b1;
                        hit_pos = j;
                    end else begin
                        pend_next       = 1'b1;
                        pend_start_next = j;
                    end
                end
            end else if (cfg_reg.mode == fmss_pkg::MODE_START) begin
                if (left_ok) begin
                    hit     = 1'b1;
                    hit_pos = j;
                end
            end else begin
                hit     = 1'b1;
                hit_pos = j;
            end
        end

        res_valid = !done_reg && (hit || in_last_reg);
        res_found = hit;
        res_pos   = hit ? hit_pos : seen_inc;
        res_pos64 = 64'(res_pos);
    end

    // text state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg    <= '0;
            pending_reg       <= 1'b0;
            pending_start_reg <= '0;
            done_reg          <= 1'b0;
        end else if (proc) begin
            if (in_last_reg) begin
                bytes_seen_reg    <= '0;
                pending_reg       <= 1'b0;
                pending_start_reg <= '0;
                done_reg          <= 1'b0;
            end else if (!done_reg) begin
                bytes_seen_reg    <= seen_inc;
                pending_reg       <= pend_next;
                pending_start_reg <= pend_start_next;
                done_reg          <= hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && !done_reg) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= win_new[k];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= proc && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_valid) begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_pos64[31:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = out_found_reg;

    `FMSS_ASSERT(a_done_not_pending, !(done_reg && pending_reg), "pending match after result")
    `FMSS_ASSERT_IMP(a_pending_has_bytes, pending_reg, bytes_seen_reg != '0,
                     "pending match with empty text")
    `FMSS_ASSERT_IMP(a_done_has_bytes, done_reg, bytes_seen_reg != '0,
                     "result given with empty text")
    `FMSS_ASSERT_IMP(a_result_from_beat, $rose(out_valid_reg), $past(in_valid_reg),
                     "result without an input beat")

endmodule

// ===== design/fmss_match.sv =====
// Parallel compare of the pattern against the current window alignment.
module fmss_match #(
    parameter int MAX_PATTERN = 16,
    parameter int LW = $clog2(MAX_PATTERN + 1)
) (
    input  fmss_pkg::cfg_t   cfg,
    input  logic [LW-1:0]    m_len,
    input  logic [7:0]       win [MAX_PATTERN+1],
    output fmss_pkg::match_t res
);

    always_comb begin
        logic [LW-1:0] idx;
        logic          eq;
        eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            idx = m_len - LW'(1) - LW'(i);
            if (LW'(i) < m_len) begin
                if (fmss_pkg::fold(cfg.pattern[i], cfg.ignore_case) !=
                    fmss_pkg::fold(win[idx], cfg.ignore_case)) begin
                    eq = 1'b0;
                end
            end
        end
        res.eq = eq;
        res.left_name = fmss_pkg::is_name(win[m_len]);
    end

endmodule

// ===== verif/fmss_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the search block: tracks config writes and beats, predicts results.
module fmss_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [fmss_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [fmss_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // text_byte
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [31:0]                         m_tdata,  // match_position
    input  logic                                m_tuser,  // found
    output int                                  mismatches,
    output int                                  results_due
);

    typedef struct packed {
        logic        found;
        logic [31:0] position;
    } search_result_t;

    search_result_t predicted_results[$];
    search_result_t got, want;

    logic [127:0] pattern;
    logic [4:0]   pattern_len;
    logic         fold_case;
    logic [1:0]   mode;

    logic [7:0]  window [0:16];
    logic [31:0] bytes_seen;
    logic        word_waiting;
    logic [31:0] word_start;
    logic        text_done;
    int          errors;

    function automatic logic word_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= "a" && lc <= "z") || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (fold_case && c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    task automatic clear_text();
        int k;
        for (k = 0; k <= 16; k++) window[k] = 8'h00;
        bytes_seen = '0;
        word_waiting = 1'b0;
        word_start = '0;
        text_done = 1'b0;
    endtask

    // one text byte through the search; queues the result it causes, if any
    task automatic search_byte(input logic [7:0] b, input logic last);
        int unsigned m;
        int          k;
        logic [32:0] span;
        logic [31:0] cand, start;
        logic        hit, same, left_ok;
        search_result_t res;
        if (text_done) begin
            if (last) clear_text();
            return;
        end
        m = (pattern_len == 0) ? 1 : (pattern_len > 16) ? 16 : pattern_len;
        span = {1'b0, bytes_seen} + 33'd1;
        for (k = 16; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (bytes_seen != '1) bytes_seen++;
        hit = 1'b0;
        start = '0;
        // a waiting whole-word match lies left of any new one
        if (word_waiting) begin
            word_waiting = 1'b0;
            if (!word_char(b)) begin
                hit = 1'b1;
                start = word_start;
            end
        end
        if (!hit && span >= m) begin
            same = 1'b1;
            for (k = 0; k < m; k++) begin
                if (fold_byte(pattern[8*k +: 8]) != fold_byte(window[m-1-k])) same = 1'b0;
            end
            if (same) begin
                cand = 32'(span - m);
                left_ok = (cand == 0) || !word_char(window[m]);
                if ((mode & fmss_pkg::MODE_WORD) != 0) begin
                    if (left_ok) begin
                        if (last) begin
                            hit = 1'b1;
                            start = cand;
                        end else begin
                            word_waiting = 1'b1;
                            word_start = cand;
                        end
                    end
                end else if (mode == fmss_pkg::MODE_START) begin
                    if (left_ok) begin
                        hit = 1'b1;
                        start = cand;
                    end
                end else begin
                    hit = 1'b1;
                    start = cand;
                end
            end
        end
        if (hit) begin
            res.found = 1'b1;
            res.position = start;
            predicted_results.push_back(res);
            if (last) clear_text();
            else text_done = 1'b1;
        end else if (last) begin
            res.found = 1'b0;
            res.position = bytes_seen;
            predicted_results.push_back(res);
            clear_text();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pattern = '0;
            pattern_len = 5'd1;
            fold_case = 1'b0;
            mode = fmss_pkg::MODE_ANY;
            clear_text();
            predicted_results.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.found = m_tuser;
                got.position = m_tdata;
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result beat: found %0b position %0d",
                             $time, got.found, got.position);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found flag mismatch: expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        errors++;
                    end
                    if (got.position !== want.position) begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, got.position);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) search_byte(s_tdata, s_tlast);
            // a write counts from the next byte on
            if (cfg_wen) begin
                case (cfg_addr)
                    fmss_pkg::REG_PATTERN_LOW:    pattern[63:0] = cfg_wdata;
                    fmss_pkg::REG_PATTERN_HIGH:   pattern[127:64] = cfg_wdata;
                    fmss_pkg::REG_PATTERN_LENGTH: pattern_len = cfg_wdata[4:0];
                    fmss_pkg::REG_IGNORE_CASE:    fold_case = cfg_wdata[0];
                    fmss_pkg::REG_MATCH_MODE:     mode = cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
        mismatches <= errors;
        results_due <= predicted_results.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the substring search block: reset, config phases, text stimulus and verdict.
module tb;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wen = 1'b0;
    logic [fmss_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [fmss_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata = '0;  // text_byte
    logic                                s_tlast = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [31:0]                         m_tdata;       // match_position
    logic                                m_tuser;       // found
    int                                  mismatches;
    int                                  results_due;

    logic [127:0] cur_pattern = '0;
    int unsigned  cur_len = 1;
    logic [7:0]   text_buf[$];
    int           bytes_sent = 0;
    int           burst_left = 0;
    logic         steady = 1'b0;

    logic hold_request = 1'b0;
    logic hold_served = 1'b0;
    int   hold_count = 0;
    int   rx_cycle = 0;
    int   rx_style = 0;

    first_match_substring_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    fmss_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .mismatches(mismatches), .results_due(results_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("[first_match_substring_search] ERROR");
        $finish;
    end

    // result side: one long hold-off on request, otherwise changing stall styles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count == 400) hold_served = 1'b1;
        end else begin
            rx_cycle++;
            if (rx_cycle % 50 == 0) rx_style = $urandom_range(0, 3);
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= ((rx_cycle / 4) % 2 == 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = steady ? 1_000_000 : $urandom_range(1, 12);
            gap = steady ? 0 : ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                            : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_str(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // drain: no beat offered until every result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [fmss_pkg::CFG_ADDR_WIDTH-1:0] addr,
                           input logic [fmss_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_wen <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_search_config(input logic [127:0] pat, input logic [4:0] len,
                                      input logic ic, input logic [1:0] mode);
        wait_idle();
        put_reg(fmss_pkg::REG_PATTERN_LOW, pat[63:0]);
        put_reg(fmss_pkg::REG_PATTERN_HIGH, pat[127:64]);
        put_reg(fmss_pkg::REG_PATTERN_LENGTH, {59'd0, len});
        put_reg(fmss_pkg::REG_IGNORE_CASE, {63'd0, ic});
        put_reg(fmss_pkg::REG_MATCH_MODE, {62'd0, mode});
        cfg_wen <= 1'b0;
        cur_pattern = pat;
        cur_len = (len == 0) ? 1 : (len > 16) ? 16 : len;
        burst_left = 0;
    endtask

    function automatic logic [127:0] pack_pattern(input string s);
        logic [127:0] p;
        int i;
        p = '0;
        for (i = 0; i < s.len() && i < 16; i++) p[8*i +: 8] = s[i];
        return p;
    endfunction

    function automatic logic [7:0] maybe_flip(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (lc >= "a" && lc <= "z" && $urandom_range(0, 1) == 1) return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 5))
            0: return 8'("a" + $urandom_range(0, 3));
            1: return 8'("A" + $urandom_range(0, 3));
            2: return 8'("0" + $urandom_range(0, 2));
            3: return "_";
            4: return " ";
            default: return ".";
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 8'($urandom_range(0, 255));
        if (r < 4) begin
            case ($urandom_range(0, 3))
                0: return " ";
                1: return ".";
                2: return "_";
                default: return "-";
            endcase
        end
        if (r < 8) return maybe_flip(cur_pattern[8*$urandom_range(0, cur_len - 1) +: 8]);
        return 8'("a" + $urandom_range(0, 3));
    endfunction

    // random text, most of them carrying a copy of the pattern
    task automatic build_text(input int len);
        int at, i;
        text_buf.delete();
        for (i = 0; i < len; i++) text_buf.push_back(pick_text_byte());
        if (len >= cur_len && $urandom_range(0, 3) != 0) begin
            at = $urandom_range(0, len - cur_len);
            for (i = 0; i < cur_len; i++) text_buf[at+i] = maybe_flip(cur_pattern[8*i +: 8]);
        end
    endtask

    initial begin
        int           phase, n_texts, t, i;
        logic [127:0] pat;
        logic [4:0]   plen;
        logic         ic;
        logic [1:0]   mode;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: byte extremes, case folding, each mode, odd lengths
        load_search_config('0, 5'd1, 1'b0, fmss_pkg::MODE_ANY);
        text_buf.delete();
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        send_text();
        load_search_config(pack_pattern("ab"), 5'd2, 1'b0, fmss_pkg::MODE_ANY);
        send_str("xab");
        send_str("a");
        send_str("AB");
        send_str("aba");
        load_search_config(pack_pattern("ab"), 5'd2, 1'b1, fmss_pkg::MODE_ANY);
        send_str("xAb");
        load_search_config(pack_pattern("foo"), 5'd3, 1'b0, fmss_pkg::MODE_WORD);
        send_str("foo");
        send_str("x foo.");
        load_search_config(pack_pattern("fo"), 5'd2, 1'b0, fmss_pkg::MODE_START);
        send_str("a fo");
        load_search_config(pack_pattern("z"), 5'd0, 1'b0,
                           fmss_pkg::MODE_WORD | fmss_pkg::MODE_START);
        send_str("zz z");

        phase = 0;
        while (bytes_sent < 1950) begin
            for (i = 0; i < 16; i++) pat[8*i +: 8] = pick_pattern_byte();
            if ($urandom_range(0, 7) == 0) pat = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 19))
                0: plen = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
                1, 2, 3: plen = 5'($urandom_range(7, 16));
                default: plen = 5'($urandom_range(1, 4));
            endcase
            ic = 1'($urandom_range(0, 1));
            mode = 2'($urandom_range(0, 3));
            if (phase == 0) plen = 5'd16;
            if (phase == 1) begin
                pat = '1;
                plen = 5'd31;
            end
            if (phase == 2) plen = 5'd0;
            load_search_config(pat, plen, ic, mode);
            steady = ($urandom_range(0, 3) == 0);
            n_texts = $urandom_range(4, 12);
            if (phase == 3) begin
                // receiver holds off while short texts keep coming
                hold_request <= 1'b1;
                steady = 1'b1;
                n_texts = 60;
            end
            for (t = 0; t < n_texts; t++) begin
                if (phase == 3) build_text($urandom_range(1, 3));
                else if ($urandom_range(0, 7) == 0) build_text($urandom_range(1, 48));
                else build_text($urandom_range(1, 20));
                send_text();
                if ($urandom_range(0, 19) == 0) wait_idle();
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("[first_match_substring_search] OK");
        end else begin
            $display("[first_match_substring_search] ERROR");
        end
        $finish;
    end

endmodule

// ===== first_match_substring_search.f =====
+incdir+design
design/fmss_pkg.sv
design/fmss_match.sv
design/first_match_substring_search.sv
verif/fmss_result_checker.sv
verif/tb.sv
